@@ src/sbfc_pkg.sv @@
`default_nettype none
package sbfc_pkg;

    localparam int COORD_W   = 32;
    localparam int EXT_W     = 31;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int MAG_W     = COORD_W + 2;
    localparam int EPS_W     = 16;
    localparam int FRAC_BITS = 30;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DIV_LAT   = FRAC_BITS + 1;
    localparam int PIPE_LAT  = DIV_LAT + 4;
    localparam int N_FACES   = 6;
    localparam int Q_LO_W    = 16;
    localparam int Q_HI_W    = Q_W - Q_LO_W;
    localparam int PP_LO_W   = DELTA_W + Q_LO_W + 1;
    localparam int PP_HI_W   = DELTA_W + Q_HI_W + 1;
    localparam int PROD_W    = PP_HI_W + Q_LO_W + 1;
    localparam int PNT_W     = PROD_W - FRAC_BITS + 1;

    typedef struct packed {
        logic             live;
        logic             eq;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
    } div_in_t;

    function automatic logic [1:0] other_axis(input logic [1:0] a, input logic k);
        logic [1:0] r;
        if (!k)
        begin
            r = (a == 2'd0) ? 2'd1 : 2'd0;
        end
        else
        begin
            r = (a == 2'd2) ? 2'd1 : 2'd2;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/segment_box_face_crossing_unit.sv @@
`default_nettype none
// Segment against origin-centred box face crossing test. One transaction may be started in
// every clock cycle and busy never rises; each result appears on hit with done high after
// the input stage, the 31 stage quotient pipeline of the face plane divisions and the
// product, compare and result stages. Results cannot be held off.
module segment_box_face_crossing_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   start_x,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   start_y,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   start_z,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   end_x,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   end_y,
    input  wire logic signed [sbfc_pkg::COORD_W-1:0]   end_z,
    input  wire logic [sbfc_pkg::EXT_W-1:0]            extent_x,
    input  wire logic [sbfc_pkg::EXT_W-1:0]            extent_y,
    input  wire logic [sbfc_pkg::EXT_W-1:0]            extent_z,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [sbfc_pkg::EPS_W-1:0]            cfg_data,
    output logic                                       done,
    output logic                                       hit
);
    import sbfc_pkg::*;

    logic [EPS_W-1:0]          eps_reg;
    logic                      a_valid_reg;
    logic signed [COORD_W-1:0] a_s_reg [0:2];
    logic signed [DELTA_W-1:0] a_d_reg [0:2];
    logic [EXT_W-1:0]          a_e_reg [0:2];

    logic                      ln_valid_reg [0:DIV_LAT-1];
    logic signed [COORD_W-1:0] ln_s_reg [0:DIV_LAT-1][0:2];
    logic signed [DELTA_W-1:0] ln_d_reg [0:DIV_LAT-1][0:2];
    logic [EXT_W-1:0]          ln_e_reg [0:DIV_LAT-1][0:2];

    div_in_t                   div_in  [0:N_FACES-1];
    logic [Q_W-1:0]            div_q   [0:N_FACES-1];
    logic                      div_live[0:N_FACES-1];

    logic                      m_valid_reg;
    logic                      m_live_reg [0:N_FACES-1];
    logic signed [PP_LO_W-1:0] m_lo_reg   [0:N_FACES-1][0:1];
    logic signed [PP_HI_W-1:0] m_hi_reg   [0:N_FACES-1][0:1];
    logic signed [COORD_W-1:0] m_s_reg    [0:2];
    logic [EXT_W-1:0]          m_e_reg    [0:2];

    logic                      p_valid_reg;
    logic [N_FACES-1:0]        p_ok_reg;
    logic [N_FACES-1:0]        p_ok_next;
    logic                      done_reg;
    logic                      hit_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg     <= EPS_W'(1);
            a_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                ln_valid_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            a_valid_reg     <= start && !busy;
            ln_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                ln_valid_reg[i] <= ln_valid_reg[i-1];
            end
            m_valid_reg <= ln_valid_reg[DIV_LAT-1];
            p_valid_reg <= m_valid_reg;
            done_reg    <= p_valid_reg;
            hit_reg     <= p_valid_reg && (|p_ok_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        a_s_reg[0] <= start_x;
        a_s_reg[1] <= start_y;
        a_s_reg[2] <= start_z;
        a_d_reg[0] <= DELTA_W'(end_x) - DELTA_W'(start_x);
        a_d_reg[1] <= DELTA_W'(end_y) - DELTA_W'(start_y);
        a_d_reg[2] <= DELTA_W'(end_z) - DELTA_W'(start_z);
        a_e_reg[0] <= extent_x;
        a_e_reg[1] <= extent_y;
        a_e_reg[2] <= extent_z;
        for (int k = 0; k < 3; k++)
        begin
            ln_s_reg[0][k] <= a_s_reg[k];
            ln_d_reg[0][k] <= a_d_reg[k];
            ln_e_reg[0][k] <= a_e_reg[k];
        end
        for (int i = 1; i < DIV_LAT; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ln_s_reg[i][k] <= ln_s_reg[i-1][k];
                ln_d_reg[i][k] <= ln_d_reg[i-1][k];
                ln_e_reg[i][k] <= ln_e_reg[i-1][k];
            end
        end
    end

    // Faces 2a and 2a+1 are the upper and lower planes of axis a.
    always_comb
    begin
        for (int f = 0; f < N_FACES; f++)
        begin
            logic [1:0]              ax;
            logic [DELTA_W-1:0]      dmag;
            logic                    axis_ok;
            logic signed [MAG_W-1:0] num;
            logic signed [MAG_W-1:0] den;
            logic [MAG_W-1:0]        un;
            logic [MAG_W-1:0]        ud;
            logic                    sign_ok;
            ax   = 2'(f >> 1);
            dmag = a_d_reg[ax][DELTA_W-1] ? DELTA_W'(-a_d_reg[ax]) : a_d_reg[ax];
            axis_ok = (dmag != '0) && (dmag >= DELTA_W'(eps_reg));
            den  = {a_d_reg[ax], 1'b0};
            if (f[0])
            begin
                num = -$signed({3'b000, a_e_reg[ax]}) - $signed({a_s_reg[ax][COORD_W-1],
                      a_s_reg[ax], 1'b0});
            end
            else
            begin
                num = $signed({3'b000, a_e_reg[ax]}) - $signed({a_s_reg[ax][COORD_W-1],
                      a_s_reg[ax], 1'b0});
            end
            un = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
            ud = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
            sign_ok = (un == '0) || (num[MAG_W-1] == den[MAG_W-1]);
            div_in[f].live = a_valid_reg && axis_ok && sign_ok && (un <= ud);
            div_in[f].eq   = (un == ud);
            div_in[f].rem  = (un < ud) ? un : '0;
            div_in[f].den  = ud;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N_FACES; g++)
        begin : g_face
            sbfc_div u_div (
                .clk   (clk),
                .rst_n (rst_n),
                .din   (div_in[g]),
                .q     (div_q[g]),
                .live  (div_live[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int f = 0; f < N_FACES; f++)
        begin
            m_live_reg[f] <= div_live[f];
            for (int k = 0; k < 2; k++)
            begin
                m_lo_reg[f][k] <= PP_LO_W'(ln_d_reg[DIV_LAT-1][other_axis(2'(f >> 1), k[0])])
                                  * PP_LO_W'($signed({1'b0, div_q[f][Q_LO_W-1:0]}));
                m_hi_reg[f][k] <= PP_HI_W'(ln_d_reg[DIV_LAT-1][other_axis(2'(f >> 1), k[0])])
                                  * PP_HI_W'($signed({1'b0, div_q[f][Q_W-1:Q_LO_W]}));
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            m_s_reg[k] <= ln_s_reg[DIV_LAT-1][k];
            m_e_reg[k] <= ln_e_reg[DIV_LAT-1][k];
        end
        p_ok_reg <= p_ok_next;
    end

    always_comb
    begin
        for (int f = 0; f < N_FACES; f++)
        begin
            logic ok;
            ok = m_valid_reg && m_live_reg[f];
            for (int k = 0; k < 2; k++)
            begin
                logic [1:0]               b;
                logic signed [PROD_W-1:0] prod;
                logic signed [PNT_W-1:0]  pnt;
                logic signed [PNT_W:0]    dbl;
                logic signed [PNT_W:0]    lim;
                b    = other_axis(2'(f >> 1), k[0]);
                prod = ($signed(PROD_W'(m_hi_reg[f][k])) <<< Q_LO_W)
                       + PROD_W'(m_lo_reg[f][k]);
                pnt  = PNT_W'(prod >>> FRAC_BITS) + PNT_W'(m_s_reg[b]);
                dbl  = {pnt, 1'b0};
                lim  = $signed({{(PNT_W+1-EXT_W){1'b0}}, m_e_reg[b]});
                if ((dbl < -lim) || (dbl > lim))
                begin
                    ok = 1'b0;
                end
            end
            p_ok_next[f] = ok;
        end
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result without a matching started transaction");
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised outside a result cycle");
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (eps_reg == $past(cfg_data)))
        else $error("epsilon register not updated by configuration write");
    a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (|p_ok_reg) && !p_valid_reg |-> !$past(m_valid_reg))
        else $error("face crossing flagged for an empty stage");

endmodule
`default_nettype wire

@@ src/sbfc_div.sv @@
`default_nettype none
module sbfc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sbfc_pkg::div_in_t           din,
    output logic [sbfc_pkg::Q_W-1:0]         q,
    output logic                             live
);
    import sbfc_pkg::*;

    logic [MAG_W-1:0]     rem_reg  [0:FRAC_BITS];
    logic [MAG_W-1:0]     den_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] quot_reg [0:FRAC_BITS];
    logic                 eq_reg   [0:FRAC_BITS];
    logic                 live_reg [0:FRAC_BITS];
    logic [MAG_W-1:0]     rem_next [0:FRAC_BITS-1];
    logic                 bit_next [0:FRAC_BITS-1];

    // One quotient bit per stage; the remainder stays below the divisor.
    always_comb
    begin
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            logic [MAG_W:0] dbl;
            dbl = {rem_reg[i], 1'b0};
            bit_next[i] = (dbl >= {1'b0, den_reg[i]});
            if (bit_next[i])
            begin
                rem_next[i] = MAG_W'(dbl - {1'b0, den_reg[i]});
            end
            else
            begin
                rem_next[i] = dbl[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= FRAC_BITS; i++)
            begin
                live_reg[i] <= 1'b0;
            end
        end
        else
        begin
            live_reg[0] <= din.live;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                live_reg[i+1] <= live_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= din.rem;
        den_reg[0]  <= din.den;
        eq_reg[0]   <= din.eq;
        quot_reg[0] <= '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem_reg[i+1]  <= rem_next[i];
            den_reg[i+1]  <= den_reg[i];
            eq_reg[i+1]   <= eq_reg[i];
            quot_reg[i+1] <= {quot_reg[i][FRAC_BITS-2:0], bit_next[i]};
        end
    end

    assign q    = eq_reg[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}}
                                    : {1'b0, quot_reg[FRAC_BITS]};
    assign live = live_reg[FRAC_BITS];

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
    import sbfc_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] start_x, start_y, start_z;
    logic signed [COORD_W-1:0] end_x, end_y, end_z;
    logic [EXT_W-1:0]          extent_x, extent_y, extent_z;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [EPS_W-1:0]          cfg_data;
    logic                      done;
    logic                      hit;

    bit          expected_hits[$];
    int unsigned eps_model;
    int          mismatches;
    int          sender_idle_pct;

    segment_box_face_crossing_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .extent_x  (extent_x),
        .extent_y  (extent_y),
        .extent_z  (extent_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .hit       (hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 600000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit face_crossed(longint s[3], longint d[3], longint e[3],
                                        int a, bit upper);
        longint      num, den, p;
        bit [63:0]   un, ud, q, r;
        num = (upper ? e[a] : -e[a]) - 2 * s[a];
        den = 2 * d[a];
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        if (ud == 0)
            return 1'b0;
        if (un != 0 && ((num < 0) != (den < 0)))
            return 1'b0;
        q = (un << 30) / ud;
        r = (un << 30) % ud;
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        if (q > (64'd1 << 30) || (q == (64'd1 << 30) && r != 0))
            return 1'b0;
        for (int b = 0; b < 3; b++)
        begin
            if (b != a)
            begin
                p = s[b] + ((d[b] * longint'(q)) >>> 30);
                if (2 * p < -e[b] || 2 * p > e[b])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit predict_face_crossing(
        logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
        logic signed [31:0] ex, logic signed [31:0] ey, logic signed [31:0] ez,
        logic [30:0] kx, logic [30:0] ky, logic [30:0] kz);
        longint s[3], d[3], e[3];
        longint m;
        int     order[3];
        s[0] = longint'(sx); s[1] = longint'(sy); s[2] = longint'(sz);
        d[0] = longint'(ex) - s[0];
        d[1] = longint'(ey) - s[1];
        d[2] = longint'(ez) - s[2];
        e[0] = longint'({1'b0, kx});
        e[1] = longint'({1'b0, ky});
        e[2] = longint'({1'b0, kz});
        order[0] = 2; order[1] = 0; order[2] = 1;
        for (int i = 0; i < 3; i++)
        begin
            m = (d[order[i]] < 0) ? -d[order[i]] : d[order[i]];
            if (m != 0 && m >= longint'(eps_model))
            begin
                if (face_crossed(s, d, e, order[i], 1'b1)
                    || face_crossed(s, d, e, order[i], 1'b0))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        bit exp_hit;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: hit=%0b with nothing outstanding", hit);
            end
            else
            begin
                exp_hit = expected_hits.pop_front();
                if (exp_hit !== hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on hit: expected %0b, actual %0b", exp_hit, hit);
                end
            end
        end
    end

    task automatic send_segment(
        logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
        logic signed [31:0] ex, logic signed [31:0] ey, logic signed [31:0] ez,
        logic [30:0] kx, logic [30:0] ky, logic [30:0] kz);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start    <= 1'b1;
        start_x  <= sx; start_y <= sy; start_z <= sz;
        end_x    <= ex; end_y   <= ey; end_z   <= ez;
        extent_x <= kx; extent_y <= ky; extent_z <= kz;
        do
            @(posedge clk);
        while (busy);
        expected_hits.push_back(predict_face_crossing(sx, sy, sz, ex, ey, ez, kx, ky, kz));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        eps_model = 32'(value);
    endtask

    task automatic test_directed;
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_segment(mx, mx, mx, mx, mx, mx, '1, '1, '1);
        send_segment(mn, mn, mn, mn, mn, mn, '1, '1, '1);
        send_segment(mn, mn, mn, mx, mx, mx, '1, '1, '1);
        send_segment(mx, mn, mx, mn, mx, mn, '0, '0, '0);
        send_segment(mn, mn, mn, mx, mx, mx, '0, '0, '0);
        send_segment(0, 0, -32'sh0002_0000, 0, 0, 32'sh0002_0000,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(0, 0, 0, 32'sh0000_4000, 0, 0,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(-32'sh0003_0000, 0, 0, -32'sh0001_0000, 0, 0,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(32'sh0001_0000, 0, 0, 32'sh0003_0000, 0, 0,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(32'sh0003_0000, 32'sh0003_0000, 0, 32'sh0003_0000, 32'sh0003_0000,
                     32'sh0001_0000, 31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(0, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 0,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(0, -5, 0, 0, 5, 0, 31'h0000_0002, 31'h0000_0002, 31'h0000_0002);
        send_segment(0, 0, 0, 0, 0, 1, 0, 0, 0);
        send_segment(32'sh0001_0000, 32'sh0001_0001, 0, -32'sh0001_0000, 32'sh0001_0001, 0,
                     31'h0002_0000, 31'h0002_0000, 31'h0002_0000);
        send_segment(mx, 0, 0, mn, 0, 0, 31'h7FFF_FFFF, 0, 0);
        drain();
    endtask

    task automatic test_epsilon_extremes;
        write_epsilon(16'h0000);
        send_segment(0, 0, -1, 0, 0, 1, 0, 0, 0);
        send_segment(0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        write_epsilon(16'hFFFF);
        send_segment(0, 0, -32'sh0000_7FFF, 0, 0, 32'sh0000_8000, 2, 2, 2);
        send_segment(0, 0, -32'sh0000_8000, 0, 0, 32'sh0000_8000, 2, 2, 2);
        send_segment(0, 0, -32'sh0000_7FFF, 0, 0, 32'sh0000_8001, 2, 2, 2);
        drain();
    endtask

    task automatic test_random_segments(int count);
        logic signed [31:0] p[6];
        logic [30:0]        k[3];
        int                 kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            for (int a = 0; a < 3; a++)
            begin
                if (kind < 2)
                begin
                    k[a]     = 31'($urandom);
                    p[a]     = $urandom;
                    p[a + 3] = $urandom;
                end
                else
                begin
                    k[a] = (kind == 2) ? 31'($urandom_range(0, 3))
                                       : 31'($urandom_range(1, 1 << 20));
                    p[a] = int'($urandom_range(0, 4 * k[a] + 4)) - 2 * int'(k[a]) - 2;
                    case ($urandom_range(3))
                        0: p[a + 3] = p[a];
                        1: p[a + 3] = p[a] + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                        default: p[a + 3] = int'($urandom_range(0, 4 * k[a] + 4))
                                            - 2 * int'(k[a]) - 2;
                    endcase
                end
            end
            send_segment(p[0], p[1], p[2], p[3], p[4], p[5], k[0], k[1], k[2]);
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        start_x   = '0; start_y = '0; start_z = '0;
        end_x     = '0; end_y   = '0; end_z   = '0;
        extent_x  = '0; extent_y = '0; extent_z = '0;
        eps_model = 1;
        mismatches = 0;
        sender_idle_pct = 30;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_epsilon_extremes();
        write_epsilon(16'h0000);
        test_random_segments(550);
        sender_idle_pct = 51;
        write_epsilon(16'hFFFF);
        test_random_segments(550);
        sender_idle_pct = 0;
        write_epsilon(16'($urandom));
        test_random_segments(300);
        write_epsilon(16'h0001);
        test_random_segments(300);

        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
src/sbfc_pkg.sv
src/sbfc_div.sv
src/segment_box_face_crossing_unit.sv
sim/tb_top.sv
